@@ design/bdlr_pkg.sv @@
// Shared types and constants for the button debouncer with long press and auto-repeat.
// Used by bdlr_evq and button_debounce_longpress_repeat_top; depends on nothing else.
package bdlr_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_BUTTONS - 1);

  // Configuration register indexes
  localparam logic [2:0] RegActiveHigh  = 3'd0;
  localparam logic [2:0] RegRepeatEn    = 3'd1;
  localparam logic [2:0] RegDebounce    = 3'd2;
  localparam logic [2:0] RegLongPress   = 3'd3;
  localparam logic [2:0] RegRepeatDelay = 3'd4;
  localparam logic [2:0] RegRepeatPer   = 3'd5;

  typedef enum logic [1:0] {
    EV_PRESSED  = 2'd0,
    EV_LONG     = 2'd1,
    EV_REPEAT   = 2'd2,
    EV_RELEASED = 2'd3
  } ev_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_DEB_PRESS   = 3'd1,
    PH_PRESSED     = 3'd2,
    PH_LONG        = 3'd3,
    PH_REPEAT      = 3'd4,
    PH_DEB_RELEASE = 3'd5
  } phase_e;

  // One entry of the per-button state memory
  typedef struct packed {
    phase_e      phase;
    logic [15:0] countdown;
    logic        armed;
    logic        seen;
  } btn_state_t;

  // Results of one finished tick, handed to the event queue
  typedef struct packed {
    logic                         valid;
    logic [NUM_BUTTONS-1:0]       ev;
    ev_kind_e [NUM_BUTTONS-1:0]   kinds;
    logic [31:0]                  time_stamp;
    logic [7:0]                   held;
  } tick_res_t;

endpackage

@@ design/bdlr_evq.sv @@
// Event queue: holds the events of one finished tick and delivers them in
// ascending button order. Depends on bdlr_pkg.
module bdlr_evq import bdlr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tick_res_t   res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  button_index_o,
  output logic [1:0]  event_kind_o,
  output logic [31:0] event_time_o,
  output logic [7:0]  held_mask_o,
  output logic        last_of_tick_o
);

  logic [NUM_BUTTONS-1:0]     ev_q, ev_d;
  ev_kind_e [NUM_BUTTONS-1:0] kinds_q;
  logic [31:0]                time_q;
  logic [7:0]                 held_q;
  logic [IdxW-1:0]            sel;
  logic                       last;
  logic                       pop;

  always_comb begin
    sel = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (ev_q[i]) sel = IdxW'(i);
    end
  end

  assign last           = ((ev_q & (ev_q - 1'b1)) == '0);
  assign out_valid_o    = |ev_q;
  assign pop            = out_valid_o && out_ready_i;
  assign free_o         = !out_valid_o || (pop && last);
  assign button_index_o = 3'(sel);
  assign event_kind_o   = kinds_q[sel];
  assign event_time_o   = time_q;
  assign held_mask_o    = held_q;
  assign last_of_tick_o = last;

  always_comb begin
    ev_d = ev_q;
    if (pop) ev_d[sel] = 1'b0;
    if (res_i.valid) ev_d = res_i.ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= '0;
    end else begin
      ev_q <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      kinds_q <= res_i.kinds;
      time_q  <= res_i.time_stamp;
      held_q  <= res_i.held;
    end
  end

endmodule

@@ design/button_debounce_longpress_repeat_top.sv @@
// Top level of the button debouncer with long press and auto-repeat.
// Depends on bdlr_pkg and bdlr_evq.
//
// Each input transaction is one tick carrying the raw pin levels. The buttons
// are visited one per cycle while not stalled: the state of a button is read
// from a small synchronous memory, updated and written back by the update
// stage, and a new tick is taken as soon as the last button of the previous
// one has been read. The events of a tick are released together once its last
// button is done, one output transaction per cycle while the output is ready,
// in ascending button order; the next tick's final button waits only if the
// previous tick still has events undelivered. There is no clearing pass after
// reset. Configuration writes take effect for countdowns loaded afterwards.
module button_debounce_longpress_repeat_top import bdlr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  button_index_o,
  output logic [1:0]  event_kind_o,
  output logic [31:0] event_time_o,
  output logic [7:0]  held_mask_o,
  output logic        last_of_tick_o
);

  // Configuration
  logic [7:0]  act_high_q, rep_en_q;
  logic [15:0] deb_q, long_q, delay_q, period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_high_q <= 8'd16;
      rep_en_q   <= 8'd3;
      deb_q      <= 16'd50;
      long_q     <= 16'd1000;
      delay_q    <= 16'd500;
      period_q   <= 16'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegActiveHigh:  act_high_q <= cfg_data_i[7:0];
        RegRepeatEn:    rep_en_q   <= cfg_data_i[7:0];
        RegDebounce:    deb_q      <= cfg_data_i;
        RegLongPress:   long_q     <= cfg_data_i;
        RegRepeatDelay: delay_q    <= cfg_data_i;
        RegRepeatPer:   period_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Read stage: walks the buttons of the current tick
  logic                   busy_q;
  logic [IdxW-1:0]        idx_q;
  logic [NUM_BUTTONS-1:0] pins_q;
  logic [31:0]            time_q;
  logic [31:0]            tick_cnt_q;

  // Update stage
  logic                   e_valid_q;
  logic [IdxW-1:0]        e_idx_q;
  logic                   e_pr_q;
  logic                   e_last_q;
  logic [31:0]            e_time_q;
  btn_state_t             rd_q;

  btn_state_t             mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] mem_vld_q;
  logic [NUM_BUTTONS-1:0] held_q, held_d;
  logic [NUM_BUTTONS-1:0] col_ev_q, col_ev_d;
  ev_kind_e [NUM_BUTTONS-1:0] col_kinds_q, col_kinds_d;

  logic                   stall, wr_en, rd_en, in_acc, free;
  btn_state_t             nst;
  logic                   held_n, ev_v, restarted;
  ev_kind_e               ev_kind;
  logic [NUM_BUTTONS-1:0] rep_vec, pins_n, act_n;
  tick_res_t              res;

  assign rep_vec = rep_en_q[NUM_BUTTONS-1:0];
  assign pins_n  = pin_levels_i[NUM_BUTTONS-1:0];
  assign act_n   = act_high_q[NUM_BUTTONS-1:0];

  assign stall      = e_valid_q && e_last_q && !free;
  assign wr_en      = e_valid_q && !stall;
  assign rd_en      = busy_q && !stall;
  assign in_ready_o = !stall && (!busy_q || idx_q == LastIdx);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      idx_q      <= '0;
      tick_cnt_q <= '0;
      e_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q     <= 1'b1;
        idx_q      <= '0;
        tick_cnt_q <= tick_cnt_q + 32'd1;
      end else if (rd_en) begin
        if (idx_q == LastIdx) busy_q <= 1'b0;
        else idx_q <= idx_q + 1'b1;
      end
      if (!stall) e_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pins_q <= pins_n ~^ act_n;
      time_q <= tick_cnt_q;
    end
    if (rd_en) begin
      e_idx_q  <= idx_q;
      e_pr_q   <= pins_q[idx_q];
      e_last_q <= (idx_q == LastIdx);
      e_time_q <= time_q;
    end
  end

  // State memory: registered read, write back from the update stage, with
  // forwarding when the entry being read is written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[e_idx_q] <= nst;
    if (rd_en) begin
      if (wr_en && e_idx_q == idx_q) rd_q <= nst;
      else if (mem_vld_q[idx_q]) rd_q <= mem[idx_q];
      else rd_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q   <= '0;
      held_q      <= '0;
      col_ev_q    <= '0;
    end else if (wr_en) begin
      mem_vld_q[e_idx_q] <= 1'b1;
      held_q             <= held_d;
      col_ev_q           <= e_last_q ? '0 : col_ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) col_kinds_q <= col_kinds_d;
  end

  // Per-button update: edge handling first, then the countdown
  always_comb begin
    nst       = rd_q;
    held_n    = held_q[e_idx_q];
    ev_v      = 1'b0;
    ev_kind   = EV_PRESSED;
    restarted = 1'b0;
    if (e_pr_q != rd_q.seen) begin
      nst.seen = e_pr_q;
      if (e_pr_q && rd_q.phase == PH_IDLE) begin
        nst.phase     = PH_DEB_PRESS;
        nst.countdown = deb_q;
        nst.armed     = 1'b1;
        restarted     = 1'b1;
      end else if (!e_pr_q && (rd_q.phase == PH_PRESSED || rd_q.phase == PH_LONG ||
                               rd_q.phase == PH_REPEAT || rd_q.phase == PH_DEB_RELEASE)) begin
        nst.phase     = PH_DEB_RELEASE;
        nst.countdown = deb_q;
        nst.armed     = 1'b1;
        restarted     = 1'b1;
      end
    end
    if (!restarted && rd_q.armed) begin
      if (rd_q.countdown <= 16'd1) begin
        nst.armed     = 1'b0;
        nst.countdown = '0;
        case (rd_q.phase)
          PH_DEB_PRESS: begin
            if (nst.seen) begin
              nst.phase     = PH_PRESSED;
              held_n        = 1'b1;
              nst.countdown = long_q;
              nst.armed     = 1'b1;
              ev_v          = 1'b1;
              ev_kind       = EV_PRESSED;
            end else begin
              nst.phase = PH_IDLE;
              held_n    = 1'b0;
            end
          end
          PH_PRESSED: begin
            nst.phase = PH_LONG;
            if (rep_vec[e_idx_q]) begin
              nst.countdown = delay_q;
              nst.armed     = 1'b1;
            end
            ev_v    = 1'b1;
            ev_kind = EV_LONG;
          end
          PH_LONG: begin
            if (rep_vec[e_idx_q]) begin
              nst.phase     = PH_REPEAT;
              nst.countdown = period_q;
              nst.armed     = 1'b1;
              ev_v          = 1'b1;
              ev_kind       = EV_REPEAT;
            end
          end
          PH_REPEAT: begin
            nst.countdown = period_q;
            nst.armed     = 1'b1;
            ev_v          = 1'b1;
            ev_kind       = EV_REPEAT;
          end
          PH_DEB_RELEASE: begin
            if (!nst.seen) begin
              nst.phase = PH_IDLE;
              held_n    = 1'b0;
              ev_v      = 1'b1;
              ev_kind   = EV_RELEASED;
            end else begin
              nst.phase     = PH_PRESSED;
              held_n        = 1'b1;
              nst.countdown = long_q;
              nst.armed     = 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        nst.countdown = rd_q.countdown - 16'd1;
      end
    end
  end

  always_comb begin
    held_d               = held_q;
    held_d[e_idx_q]      = held_n;
    col_ev_d             = (e_idx_q == '0) ? '0 : col_ev_q;
    col_ev_d[e_idx_q]    = ev_v;
    col_kinds_d          = col_kinds_q;
    col_kinds_d[e_idx_q] = ev_kind;
  end

  always_comb begin
    res.valid      = wr_en && e_last_q;
    res.ev         = col_ev_d;
    res.kinds      = col_kinds_d;
    res.time_stamp = e_time_q;
    res.held       = 8'(held_d);
  end

  bdlr_evq u_evq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (res),
    .free_o         (free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .button_index_o (button_index_o),
    .event_kind_o   (event_kind_o),
    .event_time_o   (event_time_o),
    .held_mask_o    (held_mask_o),
    .last_of_tick_o (last_of_tick_o)
  );

  // A written entry is valid from then on.
  a_vld_after_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> mem_vld_q[$past(e_idx_q)])
    else $error("state entry not marked valid after write-back");

  // The debounced bit agrees with the phase that was written back.
  a_held_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (held_n == (nst.phase == PH_PRESSED || nst.phase == PH_LONG ||
                          nst.phase == PH_REPEAT || nst.phase == PH_DEB_RELEASE)))
    else $error("held bit inconsistent with phase");

  // A disarmed countdown is always left at zero.
  a_disarmed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !nst.armed) |-> (nst.countdown == '0))
    else $error("disarmed countdown not zero");

  // A finished tick is only handed over when the event queue can take it.
  a_handoff_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> free)
    else $error("tick results handed over while events remain");

endmodule
